// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the held-note tracker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked every clock; ignored while reset is asserted.
`define HNT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Implication checked every clock; ignored while reset is asserted.
`define HNT_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

`endif

// ===== design/hnt_pkg.sv =====
// ----------------------------------------------------------------------------
// hnt_pkg
// Types, constants and helper functions for the held-note tracker.
// ----------------------------------------------------------------------------
package hnt_pkg;

    localparam int unsigned NOTE_COUNT  = 128;
    localparam int unsigned NOTE_W      = 7;
    localparam int unsigned VEL_W       = 7;
    localparam int unsigned COUNT_W     = 8;

    // held table is scanned a chunk per cycle
    localparam int unsigned CHUNK_W     = 32;
    localparam int unsigned CHUNK_NUM   = NOTE_COUNT / CHUNK_W;
    localparam int unsigned CHUNK_SEL_W = $clog2(CHUNK_NUM);
    localparam int unsigned CHUNK_BIT_W = $clog2(CHUNK_W);
    localparam int unsigned CHUNK_CNT_W = $clog2(CHUNK_W + 1);

    localparam logic [7:0] ST_NOTE_ON  = 8'd144;
    localparam logic [7:0] ST_NOTE_OFF = 8'd128;
    localparam logic [7:0] ST_CONTROL  = 8'd176;
    localparam logic [NOTE_W-1:0] CC_SUSTAIN = 7'd64;

    typedef struct packed {
        logic [1:0]        msg_length;
        logic [7:0]        status_byte;
        logic [NOTE_W-1:0] first_data;
        logic [VEL_W-1:0]  second_data;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         thru_length;
        logic [7:0]         thru_status;
        logic [NOTE_W-1:0]  thru_first;
        logic [VEL_W-1:0]   thru_second;
        logic               pedal_down;
        logic [COUNT_W-1:0] held_count;
        logic               any_held;
        logic [NOTE_W-1:0]  lowest_note;
        logic               addressed_held;
        logic               addressed_pressed;
        logic [VEL_W-1:0]   addressed_velocity;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic                   load_in;
        logic                   do_update;
        logic                   scan_clr;
        logic                   scan_en;
        logic [CHUNK_SEL_W-1:0] scan_chunk;
        logic                   load_out;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic out_free;
    } t_status;

    function automatic logic [CHUNK_CNT_W-1:0] f_popcount(input logic [CHUNK_W-1:0] bits);
        logic [CHUNK_CNT_W-1:0] acc;
        acc = '0;
        for (int i = 0; i < CHUNK_W; i++) begin
            acc = acc + CHUNK_CNT_W'(bits[i]);
        end
        return acc;
    endfunction

    // index of lowest set bit; 0 when none set
    function automatic logic [CHUNK_BIT_W-1:0] f_lowest_set(input logic [CHUNK_W-1:0] bits);
        logic [CHUNK_BIT_W-1:0] idx;
        idx = '0;
        for (int i = CHUNK_W - 1; i >= 0; i--) begin
            if (bits[i]) begin
                idx = CHUNK_BIT_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

// ===== design/midi_held_note_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// midi_held_note_tracker_unit
// MIDI note tracker with sustain pedal; echoes each message with table summary.
//
//   channel  direction  valid          stall          beat
//   in       sink       i_in_valid     o_in_stall     i_in_item  (one message)
//   out      source     o_out_valid    i_out_stall    o_out_item (echo + summary)
//
// Sequence per message: accept, table update, chunked scan (32 held bits
//   counted per cycle), result load; the load waits while the output is full.
// The scan chunk width sets the number of scan steps.
// Reset: synchronous, active low; clears held/pressed tables and pedal flag.
//   Velocity RAM is not cleared; a velocity is only reported for a held note.
// Stalls: the result register holds a finished beat while the next message is
//   taken and processed; that message waits in its load cycle until it drains.
// ----------------------------------------------------------------------------
module midi_held_note_tracker_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  hnt_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output hnt_pkg::t_out_item o_out_item
);

    hnt_pkg::t_cmd    cmd;     // sequencer commands
    hnt_pkg::t_status status;  // output register availability

    hnt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    hnt_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_item  (o_out_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall)
    );

endmodule

// ===== design/hnt_ram.sv =====
// ----------------------------------------------------------------------------
// hnt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hnt_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/hnt_ctrl.sv =====
// ----------------------------------------------------------------------------
// hnt_ctrl
// Sequencer: accept, table update, chunked scan, result load.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hnt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  hnt_pkg::t_status i_status,
    output hnt_pkg::t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_UPDATE = 4'b0010,
        S_SCAN   = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

    t_state                          r_state, n_state;
    logic [hnt_pkg::CHUNK_SEL_W-1:0] r_chunk, n_chunk;

    localparam logic [hnt_pkg::CHUNK_SEL_W-1:0] LAST_CHUNK =
        hnt_pkg::CHUNK_SEL_W'(hnt_pkg::CHUNK_NUM - 1);

    always_comb begin
        n_state    = r_state;
        n_chunk    = r_chunk;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall    = 1'b0;
                o_cmd.load_in = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.do_update = 1'b1;
                o_cmd.scan_clr  = 1'b1;
                n_chunk         = '0;
                n_state         = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan_en    = 1'b1;
                o_cmd.scan_chunk = r_chunk;
                if (r_chunk == LAST_CHUNK) begin
                    n_chunk = '0;
                    n_state = S_FINISH;
                end else begin
                    n_chunk = r_chunk + 1'b1;
                end
            end
            S_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_chunk = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_chunk <= '0;
        end else begin
            r_state <= n_state;
            r_chunk <= n_chunk;
        end
    end

    `HNT_ASSERT_IMPL(a_load_when_free, o_cmd.load_out, i_status.out_free, "result load while output full")
    `HNT_ASSERT_IMPL(a_chunk_idle_zero, r_state == S_IDLE, r_chunk == '0, "scan counter not parked")

endmodule

// ===== design/hnt_datapath.sv =====
// ----------------------------------------------------------------------------
// hnt_datapath
// Held/pressed table, pedal flag, velocity RAM, scan accumulators, result reg.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hnt_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  hnt_pkg::t_in_item    i_in_item,
    input  hnt_pkg::t_cmd        i_cmd,
    output hnt_pkg::t_status     o_status,
    output hnt_pkg::t_out_item   o_out_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall
);

    hnt_pkg::t_in_item  r_in;
    hnt_pkg::t_out_item r_out, n_out;
    logic               r_out_valid;

    logic [hnt_pkg::NOTE_COUNT-1:0] r_held, n_held;
    logic [hnt_pkg::NOTE_COUNT-1:0] r_pressed, n_pressed;
    logic                           r_sustain, n_sustain;

    logic [hnt_pkg::COUNT_W-1:0] r_count;
    logic                        r_found;
    logic [hnt_pkg::NOTE_W-1:0]  r_lowest;

    logic is_on, is_off, is_pedal;
    logic [hnt_pkg::VEL_W-1:0] ram_rd;

    logic [hnt_pkg::CHUNK_NUM-1:0][hnt_pkg::CHUNK_W-1:0] held_chunks;
    logic [hnt_pkg::CHUNK_W-1:0]     cur_chunk;
    logic [hnt_pkg::CHUNK_CNT_W-1:0] cur_pop;
    logic [hnt_pkg::CHUNK_BIT_W-1:0] cur_low;

    assign is_on    = (r_in.status_byte == hnt_pkg::ST_NOTE_ON) && (r_in.msg_length == 2'd3);
    assign is_off   = (r_in.status_byte == hnt_pkg::ST_NOTE_OFF) && (r_in.msg_length >= 2'd2);
    assign is_pedal = (r_in.status_byte == hnt_pkg::ST_CONTROL) && (r_in.msg_length == 2'd3)
                      && (r_in.first_data == hnt_pkg::CC_SUSTAIN);

    // table update, one message
    always_comb begin
        n_held    = r_held;
        n_pressed = r_pressed;
        n_sustain = r_sustain;
        if (is_on) begin
            n_held[r_in.first_data]    = 1'b1;
            n_pressed[r_in.first_data] = 1'b1;
        end else if (is_off) begin
            if (r_held[r_in.first_data]) begin
                n_pressed[r_in.first_data] = 1'b0;
                if (!r_sustain) begin
                    n_held[r_in.first_data] = 1'b0;
                end
            end
        end else if (is_pedal) begin
            n_sustain = (r_in.second_data != '0);
            if (r_in.second_data == '0) begin
                n_held = r_held & r_pressed;  // pedal up drops released notes
            end
        end
    end

    hnt_ram #(
        .WIDTH (hnt_pkg::VEL_W),
        .DEPTH (hnt_pkg::NOTE_COUNT)
    ) u_vel_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.do_update && is_on),
        .i_wr_addr (r_in.first_data),
        .i_wr_data (r_in.second_data),
        .i_rd_addr (r_in.first_data),
        .o_rd_data (ram_rd)
    );

    assign held_chunks = r_held;
    assign cur_chunk   = held_chunks[i_cmd.scan_chunk];
    assign cur_pop     = hnt_pkg::f_popcount(cur_chunk);
    assign cur_low     = hnt_pkg::f_lowest_set(cur_chunk);

    always_comb begin
        n_out                    = r_out;
        n_out.thru_length        = r_in.msg_length;
        n_out.thru_status        = r_in.status_byte;
        n_out.thru_first         = (r_in.msg_length >= 2'd2) ? r_in.first_data : '0;
        n_out.thru_second        = (r_in.msg_length == 2'd3) ? r_in.second_data : '0;
        n_out.pedal_down         = r_sustain;
        n_out.held_count         = r_count;
        n_out.any_held           = r_found;
        n_out.lowest_note        = r_lowest;
        n_out.addressed_held     = r_held[r_in.first_data];
        n_out.addressed_pressed  = r_pressed[r_in.first_data];
        n_out.addressed_velocity = r_held[r_in.first_data] ? ram_rd : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in <= i_in_item;
        end
        if (i_cmd.scan_clr) begin
            r_count  <= '0;
            r_found  <= 1'b0;
            r_lowest <= '0;
        end else if (i_cmd.scan_en) begin
            r_count <= r_count + hnt_pkg::COUNT_W'(cur_pop);
            if (!r_found && (cur_chunk != '0)) begin
                r_found  <= 1'b1;
                r_lowest <= {i_cmd.scan_chunk, cur_low};
            end
        end
        if (i_cmd.load_out) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= '0;
            r_pressed   <= '0;
            r_sustain   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.do_update) begin
                r_held    <= n_held;
                r_pressed <= n_pressed;
                r_sustain <= n_sustain;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.out_free = !r_out_valid || !i_out_stall;
    assign o_out_item        = r_out;
    assign o_out_valid       = r_out_valid;

    `HNT_ASSERT(a_pressed_in_held, (r_pressed & ~r_held) == '0, "pressed note missing from table")
    `HNT_ASSERT_IMPL(a_pedal_up_clean, !r_sustain, (r_held & ~r_pressed) == '0, "released note kept with pedal up")

endmodule
